FILE: hdl/i4dq_pkg.sv
// ---------------------------------------------------------------------------
// i4dq_pkg
// Shared types and constants for the int4 dequantizing matrix-vector block.
// ---------------------------------------------------------------------------
package i4dq_pkg;

   // number of weight lanes: one per nibble of a packed weight byte
   localparam int LANES = 2;

   localparam int INDEX_W  = 12;
   localparam int ACT_W    = 16;
   localparam int BYTE_W   = 8;
   localparam int NIB_W    = 4;
   localparam int WGT_W    = 5;
   localparam int LPROD_W  = 21;
   localparam int ACC_W    = 40;
   localparam int SCALE_W  = 16;
   localparam int PROD_W   = 56;
   localparam int RESULT_W = 32;
   localparam int ROW_W    = 16;
   localparam int PPR_W    = 12;
   localparam int RCNT_W   = 17;
   localparam int REQ_W    = 56;
   localparam int RSP_W    = 48;
   localparam int CSR_W    = 17;

   // weight offset removed from every nibble
   localparam logic signed [WGT_W-1:0] NIB_OFFSET = 5'sd8;

   // configuration register indexes
   typedef enum logic {
      CSR_PAIRS_PER_ROW = 1'b0,
      CSR_ROW_COUNT     = 1'b1
   } csr_index_type;

   typedef logic signed [LPROD_W-1:0] lane_prod_type;

   // per-lane control from the sequencer
   typedef struct packed {
      logic wr_en;   // write the activation bank
      logic rd_en;   // read the bank for a weight item
      logic s2_en;   // advance the product stage
   } lane_ctrl_type;

   // row information that travels beside a weight item
   typedef struct packed {
      logic                      row_end;
      logic signed [SCALE_W-1:0] scale;
      logic [ROW_W-1:0]          row_index;
      logic                      last_row;
   } row_meta_type;

   typedef struct packed {
      logic         valid;
      row_meta_type meta;
   } row_tok_type;

endpackage

FILE: hdl/int4_dequant_matvec_top.sv
// ---------------------------------------------------------------------------
// int4_dequant_matvec_top
// Matrix-vector product with packed 4-bit weights and Q4.12 activations.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle while req_tready is high, loads and weight
//   bytes alike; each of the two activation banks is written or read, never both.
// rsp_tvalid for a row rises once its final weight byte has passed the registered
//   stages bank read, lane multiply, accumulate, scale and round.
// Reset: synchronous; clears counters, accumulator, pipeline valids and sets
//   pairs_per_row and row_count to 1. The activation store is not cleared.
// MAX_INPUTS must be a power of two.
module int4_dequant_matvec_top #(
   parameter int MAX_INPUTS = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   // request items
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // act_index[11:0], act_value[27:12], weight_byte[35:28], row_scale[51:36]
   input  logic [i4dq_pkg::REQ_W-1:0]         req_tdata,
   // action[0]
   input  logic                               req_tuser,
   // result items
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // row_result[31:0], row_index[47:32]
   output logic [i4dq_pkg::RSP_W-1:0]         rsp_tdata,
   // last_row
   output logic                               rsp_tlast,
   // saturated[0]
   output logic                               rsp_tuser,
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  i4dq_pkg::csr_index_type            csr_index,
   input  logic [i4dq_pkg::CSR_W-1:0]         csr_data
);
   import i4dq_pkg::*;

   localparam int BANK_DEPTH = MAX_INPUTS / 2;
   localparam int BW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam logic [31:0] BANK_MASK = 32'(BANK_DEPTH - 1);

   logic [INDEX_W-1:0]        act_index;
   logic signed [ACT_W-1:0]   act_value;
   logic [BYTE_W-1:0]         weight_byte;
   logic signed [SCALE_W-1:0] row_scale;

   logic [PPR_W-1:0]  ppr_ff;
   logic [RCNT_W-1:0] rcnt_ff;
   logic [PPR_W-1:0]  pc_ff;
   logic [ROW_W-1:0]  rc_ff;

   logic accept;
   logic wt_acc;
   logic ld_acc;
   logic row_end;
   logic last_row;
   logic ready1;
   logic ready2;
   logic take;

   logic         v1_ff;
   logic         v2_ff;
   row_meta_type meta_in;
   row_meta_type meta1_ff;
   row_meta_type meta2_ff;
   row_tok_type  tok;

   logic [31:0]   wr_ext;
   logic [31:0]   rd_ext;
   logic [BW-1:0] wr_addr;
   logic [BW-1:0] rd_addr;

   lane_ctrl_type lane_ctrl [LANES];
   lane_prod_type lane_prod [LANES];

   logic signed [RESULT_W-1:0] rsp_result;
   logic [ROW_W-1:0]           rsp_row_index;

   // unpack the request item
   assign act_index   = req_tdata[11:0];
   assign act_value   = req_tdata[27:12];
   assign weight_byte = req_tdata[35:28];
   assign row_scale   = req_tdata[51:36];

   // item handshake
   always_comb begin
      ready2     = !v2_ff || take;
      ready1     = !v1_ff || ready2;
      req_tready = ready1;
      accept     = req_tvalid && req_tready;
      wt_acc     = accept && req_tuser;
      ld_acc     = accept && !req_tuser;
   end

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_ff  <= PPR_W'(1);
         rcnt_ff <= RCNT_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PAIRS_PER_ROW: ppr_ff  <= csr_data[PPR_W-1:0];
            CSR_ROW_COUNT:     rcnt_ff <= csr_data;
            default:           ;
         endcase
      end
   end

   // row end and last row of the pass
   always_comb begin
      row_end  = ({1'b0, pc_ff} + 1'b1) >= {1'b0, ppr_ff};
      last_row = ({1'b0, rc_ff} + 1'b1) >= rcnt_ff;
      meta_in.row_end   = row_end;
      meta_in.scale     = row_scale;
      meta_in.row_index = rc_ff;
      meta_in.last_row  = last_row;
   end

   // advance pair and row counters on each weight item
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         rc_ff <= '0;
      end else if (wt_acc) begin
         if (row_end) begin
            pc_ff <= '0;
            rc_ff <= last_row ? '0 : rc_ff + 1'b1;
         end else begin
            pc_ff <= pc_ff + 1'b1;
         end
      end
   end

   // bank addresses: even entries in lane 0, odd in lane 1
   always_comb begin
      wr_ext  = (32'(act_index) >> 1) & BANK_MASK;
      rd_ext  = 32'(pc_ff) & BANK_MASK;
      wr_addr = wr_ext[BW-1:0];
      rd_addr = rd_ext[BW-1:0];
   end

   // stage valids and row information
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= wt_acc;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wt_acc) begin
         meta1_ff <= meta_in;
      end
      if (ready2) begin
         meta2_ff <= meta1_ff;
      end
   end

   assign tok.valid = v2_ff;
   assign tok.meta  = meta2_ff;

   // weight lanes
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      always_comb begin
         lane_ctrl[g].wr_en = ld_acc && (act_index[0] == 1'(g));
         lane_ctrl[g].rd_en = wt_acc;
         lane_ctrl[g].s2_en = ready2;
      end

      i4dq_lane #(
         .BANK_DEPTH (BANK_DEPTH),
         .BW         (BW)
      ) u_lane (
         .clock   (clock),
         .ctrl    (lane_ctrl[g]),
         .wr_addr (wr_addr),
         .wr_data (act_value),
         .rd_addr (rd_addr),
         .nibble  (weight_byte[g*NIB_W +: NIB_W]),
         .prod    (lane_prod[g])
      );
   end

   // accumulate, scale and emit
   i4dq_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .tok           (tok),
      .lane_prod     (lane_prod),
      .take          (take),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_result    (rsp_result),
      .rsp_row_index (rsp_row_index),
      .rsp_last      (rsp_tlast),
      .rsp_sat       (rsp_tuser)
   );

   assign rsp_tdata = {rsp_row_index, rsp_result};

endmodule

FILE: hdl/i4dq_lane.sv
// ---------------------------------------------------------------------------
// i4dq_lane
// One weight lane: a bank of the activation store, its registered read and
// the activation times (nibble - 8) product.
// ---------------------------------------------------------------------------
module i4dq_lane #(
   parameter int BANK_DEPTH = 2048,
   parameter int BW         = 11
) (
   input  logic                               clock,
   input  i4dq_pkg::lane_ctrl_type            ctrl,
   input  logic [BW-1:0]                      wr_addr,
   input  logic signed [i4dq_pkg::ACT_W-1:0]  wr_data,
   input  logic [BW-1:0]                      rd_addr,
   input  logic [i4dq_pkg::NIB_W-1:0]         nibble,
   output i4dq_pkg::lane_prod_type            prod
);
   import i4dq_pkg::*;

   logic signed [ACT_W-1:0] bank [BANK_DEPTH];
   logic signed [ACT_W-1:0] act_ff;
   logic [NIB_W-1:0]        nib_ff;
   logic signed [WGT_W-1:0] wgt;
   logic signed [LPROD_W-1:0] act_ext;
   logic signed [LPROD_W-1:0] wgt_ext;
   lane_prod_type           prod_in;
   lane_prod_type           prod_ff;

   // write a loaded activation
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         bank[wr_addr] <= wr_data;
      end
   end

   // read the bank and hold the nibble for a weight item
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         act_ff <= bank[rd_addr];
         nib_ff <= nibble;
      end
   end

   // remove the offset and multiply
   always_comb begin
      wgt     = $signed({1'b0, nib_ff}) - NIB_OFFSET;
      act_ext = LPROD_W'(act_ff);
      wgt_ext = LPROD_W'(wgt);
      prod_in = act_ext * wgt_ext;
   end

   always_ff @(posedge clock) begin
      if (ctrl.s2_en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

FILE: hdl/i4dq_merge.sv
// ---------------------------------------------------------------------------
// i4dq_merge
// Merge stage: adds the lane products into the row accumulator, scales the
// finished row sum, rounds to Q20.12, saturates and holds the result item.
// ---------------------------------------------------------------------------
module i4dq_merge (
   input  logic                                  clock,
   input  logic                                  reset,
   input  i4dq_pkg::row_tok_type                 tok,
   input  i4dq_pkg::lane_prod_type               lane_prod [i4dq_pkg::LANES],
   output logic                                  take,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic signed [i4dq_pkg::RESULT_W-1:0]  rsp_result,
   output logic [i4dq_pkg::ROW_W-1:0]            rsp_row_index,
   output logic                                  rsp_last,
   output logic                                  rsp_sat
);
   import i4dq_pkg::*;

   localparam int RND_W = PROD_W - 12;
   localparam logic signed [RND_W-1:0] RND_MAX = 44'sd2147483647;
   localparam logic signed [RND_W-1:0] RND_MIN = -44'sd2147483648;
   localparam logic signed [PROD_W-1:0] RND_HALF = 56'sd2048;

   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] sum_in;

   logic                      v3_ff;
   logic signed [ACC_W-1:0]   sum3_ff;
   logic signed [SCALE_W-1:0] scale3_ff;
   logic [ROW_W-1:0]          row3_ff;
   logic                      last3_ff;

   logic                      v4_ff;
   logic signed [PROD_W-1:0]  prod4_in;
   logic signed [PROD_W-1:0]  prod4_ff;
   logic [ROW_W-1:0]          row4_ff;
   logic                      last4_ff;

   logic signed [PROD_W-1:0]  biased;
   logic signed [RND_W-1:0]   rnd;
   logic signed [RESULT_W-1:0] res_in;
   logic                      sat_in;

   logic                      rsp_valid_ff;
   logic signed [RESULT_W-1:0] rsp_result_ff;
   logic [ROW_W-1:0]          rsp_row_ff;
   logic                      rsp_last_ff;
   logic                      rsp_sat_ff;

   logic ready_out;
   logic ready4;
   logic ready3;
   logic row_done;

   // stage handshakes, from the output back
   always_comb begin
      ready_out = !rsp_valid_ff || rsp_ready;
      ready4    = !v4_ff || ready_out;
      ready3    = !v3_ff || ready4;
      take      = tok.valid && (!tok.meta.row_end || ready3);
      row_done  = take && tok.meta.row_end;
   end

   // add the lane products to the running row sum
   always_comb begin
      sum_in = acc_ff;
      for (int i = 0; i < LANES; i++) begin
         sum_in = sum_in + ACC_W'(lane_prod[i]);
      end
   end

   // accumulate, clear at the row end
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (take) begin
         acc_ff <= tok.meta.row_end ? '0 : sum_in;
      end
   end

   // capture the finished row sum
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (ready3) begin
         v3_ff <= row_done;
      end
   end

   always_ff @(posedge clock) begin
      if (row_done) begin
         sum3_ff   <= sum_in;
         scale3_ff <= tok.meta.scale;
         row3_ff   <= tok.meta.row_index;
         last3_ff  <= tok.meta.last_row;
      end
   end

   // scale the row sum
   assign prod4_in = PROD_W'(sum3_ff) * PROD_W'(scale3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (ready4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready4) begin
         prod4_ff <= prod4_in;
         row4_ff  <= row3_ff;
         last4_ff <= last3_ff;
      end
   end

   // round half up to Q20.12 and clip to 32 bits
   always_comb begin
      biased = prod4_ff + RND_HALF;
      rnd    = biased[PROD_W-1:12];
      sat_in = 1'b0;
      res_in = rnd[RESULT_W-1:0];
      if (rnd > RND_MAX) begin
         res_in = RND_MAX[RESULT_W-1:0];
         sat_in = 1'b1;
      end else if (rnd < RND_MIN) begin
         res_in = RND_MIN[RESULT_W-1:0];
         sat_in = 1'b1;
      end
   end

   // hold the result item until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready_out) begin
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out) begin
         rsp_result_ff <= res_in;
         rsp_row_ff    <= row4_ff;
         rsp_last_ff   <= last4_ff;
         rsp_sat_ff    <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result    = rsp_result_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_sat       = rsp_sat_ff;

endmodule

FILE: hdl/i4dq_checker.sv
// ---------------------------------------------------------------------------
// i4dq_checker
// Port-level checks for the int4 dequantizing matrix-vector block.
// ---------------------------------------------------------------------------
module i4dq_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [i4dq_pkg::RSP_W-1:0]  rsp_tdata,
   input logic                        rsp_tlast,
   input logic                        rsp_tuser,
   input logic                        csr_valid,
   input logic                        csr_ready
);
   import i4dq_pkg::*;

   // a stalled result item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // a clipped result sits at one of the two limits
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[31:0] == 32'h7FFF_FFFF) || (rsp_tdata[31:0] == 32'h8000_0000))
      else $error("saturated flag without a clipped value");

   // configuration writes are never stalled
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

   // reset drops any pending result
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind int4_dequant_matvec_top i4dq_checker u_i4dq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
